FILE: rtl/core/alc_pkg.sv
// alc_pkg: shared constants, types and tables for arc_length_on_circle
// no dependencies
`default_nettype none
package alc_pkg;
	localparam int CORDIC_STAGES = 18;
	localparam int FRAC_BITS = 16;
	localparam int CW = 36;   // cordic x/y width: values below 2^35 after growth, signed
	localparam int ZW = 36;   // angle width, Q32 signed
	localparam logic signed [ZW-1:0] PI_Q32 = 36'sh3243F6A89;
	localparam logic signed [ZW-1:0] TWO_PI_Q32 = 36'sh6487ED511;
	localparam int AW = 3 + FRAC_BITS;  // rounded angle width
	localparam logic [AW-1:0] TWO_PI_F =
		AW'((64'h6487ED511 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	function automatic logic signed [ZW-1:0] atan_t(input int i);
		logic signed [ZW-1:0] t;
		case (i)
			0: t = 36'sd3373259426;
			1: t = 36'sd1991351318;
			2: t = 36'sd1052175346;
			3: t = 36'sd534100635;
			4: t = 36'sd268086748;
			5: t = 36'sd134174063;
			6: t = 36'sd67103403;
			7: t = 36'sd33553749;
			8: t = 36'sd16777131;
			9: t = 36'sd8388597;
			10: t = 36'sd4194303;
			default: t = ZW'(64'd2097152 >> (i - 11));
		endcase
		return t;
	endfunction

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} cvec_t;
endpackage
`default_nettype wire

FILE: rtl/core/alc_norm.sv
// alc_norm: point minus centre, half-plane fold and normalising shift
// depends on alc_pkg
`default_nettype none
module alc_norm (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [31:0] px,
	input wire logic signed [31:0] py,
	input wire logic signed [31:0] cx,
	input wire logic signed [31:0] cy,
	output alc_pkg::cvec_t vec
);
	import alc_pkg::*;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [33:0] fx, fy;
	logic [33:0] ax, ay, mag;
	logic [5:0] sh;
	logic neg;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(px) - 33'(cx);
			dy_s1 <= 33'(py) - 33'(cy);
		end
	end

	always_comb begin
		neg = dx_s1[32];
		fx = neg ? -34'(dx_s1) : 34'(dx_s1);
		fy = neg ? -34'(dy_s1) : 34'(dy_s1);
		ax = fx;
		ay = fy[33] ? 34'(-fy) : 34'(fy);
		mag = (ax > ay) ? ax : ay;
		sh = 6'd0;
		for (int b = 0; b < 33; b++)
			if (mag[b]) sh = 6'(32 - b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec.x <= CW'(fx) <<< sh;
			vec.y <= CW'(fy) <<< sh;
			vec.z <= neg ? PI_Q32 : '0;
			vec.zero <= (dx_s1 == 0) && (dy_s1 == 0);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/alc_cordic.sv
// alc_cordic: pipelined vectoring cordic, one stage per register, wraps angle
// depends on alc_pkg
`default_nettype none
module alc_cordic (
	input wire logic clk,
	input wire logic en,
	input alc_pkg::cvec_t vin,
	output logic signed [alc_pkg::ZW-1:0] ang
);
	import alc_pkg::*;
	cvec_t st_q [CORDIC_STAGES+1];
	logic signed [ZW-1:0] zf;

	assign st_q[0] = vin;
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				st_q[i+1].zero <= st_q[i].zero;
				if (!st_q[i].y[CW-1]) begin
					st_q[i+1].x <= st_q[i].x + (st_q[i].y >>> i);
					st_q[i+1].y <= st_q[i].y - (st_q[i].x >>> i);
					st_q[i+1].z <= st_q[i].z + atan_t(i);
				end else begin
					st_q[i+1].x <= st_q[i].x - (st_q[i].y >>> i);
					st_q[i+1].y <= st_q[i].y + (st_q[i].x >>> i);
					st_q[i+1].z <= st_q[i].z - atan_t(i);
				end
			end
		end
	end

	always_comb begin
		zf = st_q[CORDIC_STAGES].z;
		if (zf < 0) zf = zf + TWO_PI_Q32;
		if (zf >= TWO_PI_Q32) zf = zf - TWO_PI_Q32;
		if (st_q[CORDIC_STAGES].zero) zf = '0;
	end

	always_ff @(posedge clk) begin
		if (en) ang <= zf;
	end
endmodule
`default_nettype wire

FILE: rtl/core/alc_scale.sv
// alc_scale: angle difference, rounding, direction and radius product
// depends on alc_pkg
`default_nettype none
module alc_scale (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [alc_pkg::ZW-1:0] a1,
	input wire logic signed [alc_pkg::ZW-1:0] a2,
	input wire logic [30:0] r,
	input wire logic cw,
	output logic [33:0] arc_length
);
	import alc_pkg::*;
	logic signed [ZW-1:0] d;
	logic [ZW-1:0] dr;
	logic [AW-1:0] ang_s1;
	logic [30:0] r_s1;
	logic [30+AW:0] prod_s2;
	logic [AW-1:0] df;

	always_comb begin
		d = a2 - a1;
		if (d < 0) d = d + TWO_PI_Q32;
		dr = ZW'(d) + ZW'(64'd1 << (31 - FRAC_BITS));
		df = AW'(dr >> (32 - FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= cw ? (TWO_PI_F - df) : df;
			r_s1 <= r;
			prod_s2 <= (31 + AW)'(r_s1) * (31 + AW)'(ang_s1);
			arc_length <= 34'((prod_s2 + (31 + AW)'(64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/arc_length_on_circle.sv
// arc_length_on_circle: top level, arc length from two cordic atan2 angles
// depends on alc_pkg, alc_norm, alc_cordic, alc_scale
// usage:
//  - a query transfer happens on a clock edge with start high and busy low
//  - busy is tied low: one query may be started every cycle
//  - each query gives exactly one result, arc_length with done high for one cycle
//  - stages: subtract, normalise, cordic stages, wrap, round and direction,
//    multiply, final rounding
//  - throughput is one query per cycle, set by the fully pipelined cordic
//  - both points run through their own cordic pipeline side by side
//  - the receiver cannot stall, so the pipeline always advances
//  - reset clears the valid chain only; data registers hold no reset
//  - radius and direction ride a delay line alongside the angles
`default_nettype none
module arc_length_on_circle (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [31:0] center_x,
	input wire logic signed [31:0] center_y,
	input wire logic [30:0] radius,
	input wire logic signed [31:0] start_x,
	input wire logic signed [31:0] start_y,
	input wire logic signed [31:0] end_x,
	input wire logic signed [31:0] end_y,
	input wire logic clockwise,
	output logic done,
	output logic [33:0] arc_length
);
	import alc_pkg::*;
	localparam int LAT = CORDIC_STAGES + 6;
	localparam int DL = CORDIC_STAGES + 3;  // side data delay to the scale input

	cvec_t v1, v2;
	logic signed [ZW-1:0] a1, a2;
	logic [LAT-1:0] vld_q;
	logic [30:0] r_q [DL];
	logic cw_q [DL];

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end

	// radius and direction delay line
	always_ff @(posedge clk) begin
		r_q[0] <= radius;
		cw_q[0] <= clockwise;
		for (int i = 1; i < DL; i++) begin
			r_q[i] <= r_q[i-1];
			cw_q[i] <= cw_q[i-1];
		end
	end

	alc_norm u_norm_s (.clk(clk), .en(1'b1), .px(start_x), .py(start_y),
		.cx(center_x), .cy(center_y), .vec(v1));
	alc_norm u_norm_e (.clk(clk), .en(1'b1), .px(end_x), .py(end_y),
		.cx(center_x), .cy(center_y), .vec(v2));
	alc_cordic u_cordic_s (.clk(clk), .en(1'b1), .vin(v1), .ang(a1));
	alc_cordic u_cordic_e (.clk(clk), .en(1'b1), .vin(v2), .ang(a2));
	alc_scale u_scale (.clk(clk), .en(1'b1), .a1(a1), .a2(a2),
		.r(r_q[DL-1]), .cw(cw_q[DL-1]), .arc_length(arc_length));
endmodule
`default_nettype wire

FILE: rtl/core/alc_check.sv
// alc_check: port-level checker for arc_length_on_circle, with bind
// depends on alc_pkg
`default_nettype none
module alc_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [33:0] arc_length
);
	import alc_pkg::*;
	localparam int LAT = CORDIC_STAGES + 6;

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done) else $error("result missing");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("unrequested result");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(arc_length)) else $error("unknown result");
endmodule

bind arc_length_on_circle alc_check u_alc_check (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .arc_length(arc_length));
`default_nettype wire
